[design/fdt_struct_block_checker_macros.svh]
// ----------------------------------------------------------------------------
// FDT structure block checker: assertion macros
// Shorthand for the concurrent checks in the checker's top level.
// ----------------------------------------------------------------------------
`ifndef FDT_STRUCT_BLOCK_CHECKER_MACROS_SVH
`define FDT_STRUCT_BLOCK_CHECKER_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define FDTSBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fdtsbc check failed");

// Consequence that must hold in the cycle after the trigger
`define FDTSBC_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("fdtsbc check failed");

`endif

[design/fdtsbc_pkg.sv]
// ----------------------------------------------------------------------------
// FDT structure block checker package
// Widths, token codes, walk phases, status codes and shared structs.
// ----------------------------------------------------------------------------
package fdtsbc_pkg;

  // Field and state widths
  localparam int WordW     = 32;
  localparam int WcW       = 24;  // structure word count width
  localparam int StrW      = 24;  // strings area size width
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 24;
  localparam int MaxDepth  = 64;
  localparam int DepthW    = 7;
  localparam int StatusW   = 4;
  localparam int KindW     = 3;
  localparam int PhaseW    = 3;
  localparam int PadW      = WordW - 1;  // padded value length in words, no wrap

  // Structure block tokens
  localparam logic [WordW-1:0] TokBeginNode = 32'd1;
  localparam logic [WordW-1:0] TokEndNode   = 32'd2;
  localparam logic [WordW-1:0] TokProp      = 32'd3;
  localparam logic [WordW-1:0] TokNop       = 32'd4;
  localparam logic [WordW-1:0] RootName     = 32'd0;

  // Command codes
  localparam logic FuncStart = 1'b0;

  // Walk phases
  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhRoot0 = 3'd1;
  localparam logic [PhaseW-1:0] PhRoot1 = 3'd2;
  localparam logic [PhaseW-1:0] PhToken = 3'd3;
  localparam logic [PhaseW-1:0] PhName  = 3'd4;
  localparam logic [PhaseW-1:0] PhHlen  = 3'd5;
  localparam logic [PhaseW-1:0] PhHoff  = 3'd6;
  localparam logic [PhaseW-1:0] PhValue = 3'd7;

  typedef enum logic [CfgIdxW-1:0] {
    RegStructWordCount = 1'b0,
    RegStringsSize     = 1'b1
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 4'd0,
    StComplete   = 4'd1,
    StEndBetween = 4'd2,
    StBadToken   = 4'd3,
    StBadRoot    = 4'd4,
    StNameTrunc  = 4'd5,
    StPropAfter  = 4'd6,
    StHdrTrunc   = 4'd7,
    StNameOffOut = 4'd8,
    StValueTrunc = 4'd9,
    StDepthOver  = 4'd10,
    StIgnored    = 4'd11
  } status_e;

  typedef enum logic [KindW-1:0] {
    KindCont      = 3'd0,
    KindBeginNode = 3'd1,
    KindEndNode   = 3'd2,
    KindProp      = 3'd3,
    KindNop       = 3'd4
  } kind_e;

  // Walk state carried from beat to beat
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [DepthW-1:0] depth;
    logic              subnode_seen;
    logic [WcW-1:0]    consumed;
    logic [WcW-1:0]    value_left;
    logic [WordW-1:0]  held_length;
    logic [WordW-1:0]  held_offset;
  } walk_t;

  // One result beat
  typedef struct packed {
    status_e          status;
    kind_e            token_kind;
    logic [DepthW-1:0] nest_depth;
    logic [WordW-1:0] value_length;
    logic [WordW-1:0] name_offset;
  } result_t;

endpackage

[design/fdtsbc_in_if.sv]
// ----------------------------------------------------------------------------
// FDT structure block checker input channel
// Valid/ready channel carrying a command and one structure word.
// ----------------------------------------------------------------------------
interface fdtsbc_in_if;
  import fdtsbc_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [WordW-1:0] word;

  modport source (output valid, output func, output word, input ready);
  modport sink   (input valid, input func, input word, output ready);
endinterface

[design/fdtsbc_out_if.sv]
// ----------------------------------------------------------------------------
// FDT structure block checker result channel
// Valid/ready channel carrying the per-word check result.
// ----------------------------------------------------------------------------
interface fdtsbc_out_if;
  import fdtsbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [KindW-1:0]   token_kind;
  logic [DepthW-1:0]  nest_depth;
  logic [WordW-1:0]   value_length;
  logic [WordW-1:0]   name_offset;

  modport source (output valid, output status, output token_kind, output nest_depth,
                  output value_length, output name_offset, input ready);
  modport sink   (input valid, input status, input token_kind, input nest_depth,
                  input value_length, input name_offset, output ready);
endinterface

[design/fdtsbc_cfg_if.sv]
// ----------------------------------------------------------------------------
// FDT structure block checker configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fdtsbc_cfg_if;
  import fdtsbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/fdtsbc_step.sv]
// ----------------------------------------------------------------------------
// FDT structure block checker walk step
// Classifies one structure word against the walk state and computes the
// next state and the result beat.
// ----------------------------------------------------------------------------
module fdtsbc_step (
  input  fdtsbc_pkg::walk_t              walk_q_i,
  input  logic                           func_i,
  input  logic [fdtsbc_pkg::WordW-1:0]   word_i,
  input  logic [fdtsbc_pkg::WcW-1:0]     word_count_i,
  input  logic [fdtsbc_pkg::StrW-1:0]    strings_size_i,
  output fdtsbc_pkg::walk_t              walk_d_o,
  output fdtsbc_pkg::result_t            result_o
);
  import fdtsbc_pkg::*;

  logic            in_block;
  logic [WcW-1:0]  consumed_inc;
  logic [WcW-1:0]  words_left;
  logic [PadW-1:0] pad_words;
  logic [WcW-1:0]  value_left_dec;
  logic            zero_byte;
  walk_t           walk_d;
  status_e         status;
  kind_e           kind;

  // Bound checks and shared arithmetic
  assign in_block       = walk_q_i.consumed < word_count_i;
  assign consumed_inc   = walk_q_i.consumed + WcW'(1);
  assign words_left     = word_count_i - consumed_inc;
  assign pad_words      = PadW'(({1'b0, walk_q_i.held_length} + 33'd3) >> 2);
  assign value_left_dec = walk_q_i.value_left - WcW'(walk_q_i.value_left != '0);
  assign zero_byte      = (word_i[7:0] == 8'd0) || (word_i[15:8] == 8'd0) ||
                          (word_i[23:16] == 8'd0) || (word_i[31:24] == 8'd0);

  // Advance the walk by one beat
  always_comb begin
    walk_d = walk_q_i;
    status = StOk;
    kind   = KindCont;
    if (func_i == FuncStart) begin
      walk_d       = '0;
      walk_d.phase = PhRoot0;
    end else begin
      case (walk_q_i.phase)
        PhRoot0: begin
          kind = KindBeginNode;
          if (!in_block || word_i != TokBeginNode) begin
            status       = StBadRoot;
            walk_d.phase = PhIdle;
          end else begin
            walk_d.consumed = consumed_inc;
            walk_d.phase    = PhRoot1;
          end
        end
        PhRoot1: begin
          if (!in_block || word_i != RootName) begin
            status       = StBadRoot;
            walk_d.phase = PhIdle;
          end else begin
            walk_d.consumed = consumed_inc;
            walk_d.phase    = PhToken;
          end
        end
        PhToken: begin
          if (!in_block) begin
            status       = StEndBetween;
            walk_d.phase = PhIdle;
          end else begin
            walk_d.consumed = consumed_inc;
            case (word_i)
              TokNop: kind = KindNop;
              TokEndNode: begin
                kind = KindEndNode;
                if (walk_q_i.depth == '0) begin
                  status       = StComplete;
                  walk_d.phase = PhIdle;
                end else begin
                  walk_d.depth        = walk_q_i.depth - DepthW'(1);
                  walk_d.subnode_seen = 1'b1;
                end
              end
              TokBeginNode: begin
                kind = KindBeginNode;
                if (walk_q_i.depth >= DepthW'(MaxDepth)) begin
                  status       = StDepthOver;
                  walk_d.phase = PhIdle;
                end else begin
                  walk_d.depth        = walk_q_i.depth + DepthW'(1);
                  walk_d.subnode_seen = 1'b0;
                  walk_d.phase        = PhName;
                end
              end
              TokProp: begin
                kind               = KindProp;
                walk_d.held_length = '0;
                walk_d.held_offset = '0;
                if (walk_q_i.subnode_seen) begin
                  status       = StPropAfter;
                  walk_d.phase = PhIdle;
                end else if (words_left < WcW'(2)) begin
                  status       = StHdrTrunc;
                  walk_d.phase = PhIdle;
                end else begin
                  walk_d.phase = PhHlen;
                end
              end
              default: begin
                status       = StBadToken;
                walk_d.phase = PhIdle;
              end
            endcase
          end
        end
        PhName: begin
          if (!in_block) begin
            status       = StNameTrunc;
            walk_d.phase = PhIdle;
          end else begin
            walk_d.consumed = consumed_inc;
            if (zero_byte) walk_d.phase = PhToken;
          end
        end
        PhHlen: begin
          if (!in_block) begin
            status       = StHdrTrunc;
            walk_d.phase = PhIdle;
          end else begin
            walk_d.consumed    = consumed_inc;
            walk_d.held_length = word_i;
            walk_d.phase       = PhHoff;
          end
        end
        PhHoff: begin
          if (!in_block) begin
            status       = StHdrTrunc;
            walk_d.phase = PhIdle;
          end else begin
            walk_d.consumed    = consumed_inc;
            walk_d.held_offset = word_i;
            if (word_i >= {{(WordW-StrW){1'b0}}, strings_size_i}) begin
              status       = StNameOffOut;
              walk_d.phase = PhIdle;
            end else if (pad_words > {{(PadW-WcW){1'b0}}, words_left}) begin
              status       = StValueTrunc;
              walk_d.phase = PhIdle;
            end else begin
              // padded length fits the remaining words, so the low bits hold it
              walk_d.value_left = pad_words[WcW-1:0];
              walk_d.phase      = (pad_words != '0) ? PhValue : PhToken;
            end
          end
        end
        PhValue: begin
          if (!in_block) begin
            status       = StValueTrunc;
            walk_d.phase = PhIdle;
          end else begin
            walk_d.consumed   = consumed_inc;
            walk_d.value_left = value_left_dec;
            if (value_left_dec == '0) walk_d.phase = PhToken;
          end
        end
        default: begin
          status       = StIgnored;
          walk_d.phase = PhIdle;
        end
      endcase
    end
  end

  // Report the state after this word
  assign walk_d_o                = walk_d;
  assign result_o.status         = status;
  assign result_o.token_kind     = kind;
  assign result_o.nest_depth     = walk_d.depth;
  assign result_o.value_length   = walk_d.held_length;
  assign result_o.name_offset    = walk_d.held_offset;

endmodule

[design/fdt_struct_block_checker.sv]
// The result beat of an accepted word is registered in the output register in the next cycle.
// Throughput: one word per cycle; a word is taken whenever the output register is
// empty or its beat leaves in the same cycle.
// Reset (rst_ni low, asynchronous): walk goes idle, counters and held header values clear,
// both configuration registers read zero, output register empty.
// ----------------------------------------------------------------------------
// FDT structure block checker
// Walks a flattened device tree structure block word by word and reports
// token kind, nesting depth, property header values and errors per word.
// ----------------------------------------------------------------------------
module fdt_struct_block_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  fdtsbc_in_if.sink    in_i,
  fdtsbc_out_if.source out_o,
  fdtsbc_cfg_if.sink   cfg_i
);
  import fdtsbc_pkg::*;

  `include "fdt_struct_block_checker_macros.svh"

  logic [WcW-1:0]  word_count_q;
  logic [StrW-1:0] strings_size_q;
  walk_t           walk_q;
  walk_t           walk_d;
  result_t         result_d;
  result_t         result_q;
  logic            out_valid_q;
  logic            in_fire;

  // Take configuration writes at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q   <= '0;
      strings_size_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        RegStructWordCount: word_count_q   <= cfg_i.data;
        RegStringsSize:     strings_size_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Accept a word when the output register is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  fdtsbc_step u_step (
    .walk_q_i       (walk_q),
    .func_i         (in_i.func),
    .word_i         (in_i.word),
    .word_count_i   (word_count_q),
    .strings_size_i (strings_size_q),
    .walk_d_o       (walk_d),
    .result_o       (result_d)
  );

  // Advance walk state on each accepted beat; all-zero state is the idle phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= '0;
    end else if (in_fire) begin
      walk_q <= walk_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) result_q <= result_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = result_q.status;
  assign out_o.token_kind    = result_q.token_kind;
  assign out_o.nest_depth    = result_q.nest_depth;
  assign out_o.value_length  = result_q.value_length;
  assign out_o.name_offset   = result_q.name_offset;

  // Checks
  `FDTSBC_ASSERT(a_depth_bound, walk_q.depth <= DepthW'(MaxDepth))
  `FDTSBC_ASSERT_NEXT(a_stop_on_status, in_fire && result_d.status != StOk, walk_q.phase == PhIdle)
  `FDTSBC_ASSERT_NEXT(a_beat_registered, in_fire, out_valid_q)

endmodule

[tb/fdtsbc_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDT structure block walk scoreboard
// Predicts the checker's result for every accepted word from a software copy
// of the walk state and configuration, then matches result beats in order.
// ----------------------------------------------------------------------------
package fdtsbc_tb_pkg;
  import fdtsbc_pkg::*;

  class fdt_walk_scoreboard;
    // Configuration copy
    int unsigned word_count;
    int unsigned strings_bytes;

    // Walk state copy
    logic [PhaseW-1:0] phase;
    int unsigned       depth;
    bit                subnode_seen;
    int unsigned       consumed;
    int unsigned       value_left;
    logic [WordW-1:0]  held_length;
    logic [WordW-1:0]  held_offset;

    // Expected result beats, oldest first
    result_t     expected_q[$];
    int unsigned failures;
    int unsigned results_checked;
    int unsigned walks_completed;
    int unsigned walks_failed;
    bit [11:0]   status_seen;

    function new();
      word_count    = 0;
      strings_bytes = 0;
      phase         = PhIdle;
      clear_walk();
    endfunction

    function void clear_walk();
      depth        = 0;
      subnode_seen = 1'b0;
      consumed     = 0;
      value_left   = 0;
      held_length  = '0;
      held_offset  = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      if (idx == RegStructWordCount) begin
        word_count = data;
      end else begin
        strings_bytes = data;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the walk by one accepted word and queue its expected beat
    function void note_word(logic func, logic [WordW-1:0] w);
      status_e         st;
      kind_e           kd;
      bit              inb;
      longint unsigned vw;
      longint unsigned room;
      result_t         exp;
      st  = StOk;
      kd  = KindCont;
      inb = consumed < word_count;
      if (func == FuncStart) begin
        clear_walk();
        phase = PhRoot0;
      end else begin
        case (phase)
          PhRoot0: begin
            kd = KindBeginNode;
            if (!inb || w != TokBeginNode) begin
              st    = StBadRoot;
              phase = PhIdle;
            end else begin
              consumed++;
              phase = PhRoot1;
            end
          end
          PhRoot1: begin
            if (!inb || w != RootName) begin
              st    = StBadRoot;
              phase = PhIdle;
            end else begin
              consumed++;
              phase = PhToken;
            end
          end
          PhToken: begin
            if (!inb) begin
              st    = StEndBetween;
              phase = PhIdle;
            end else begin
              consumed++;
              if (w == TokNop) begin
                kd = KindNop;
              end else if (w == TokEndNode) begin
                kd = KindEndNode;
                if (depth == 0) begin
                  st    = StComplete;
                  phase = PhIdle;
                end else begin
                  depth--;
                  subnode_seen = 1'b1;
                end
              end else if (w == TokBeginNode) begin
                kd = KindBeginNode;
                if (depth >= MaxDepth) begin
                  st    = StDepthOver;
                  phase = PhIdle;
                end else begin
                  depth++;
                  subnode_seen = 1'b0;
                  phase        = PhName;
                end
              end else if (w == TokProp) begin
                kd          = KindProp;
                held_length = '0;
                held_offset = '0;
                if (subnode_seen) begin
                  st    = StPropAfter;
                  phase = PhIdle;
                end else if (word_count - consumed < 2) begin
                  st    = StHdrTrunc;
                  phase = PhIdle;
                end else begin
                  phase = PhHlen;
                end
              end else begin
                st    = StBadToken;
                phase = PhIdle;
              end
            end
          end
          PhName: begin
            if (!inb) begin
              st    = StNameTrunc;
              phase = PhIdle;
            end else begin
              consumed++;
              if (w[7:0] == 8'h00 || w[15:8] == 8'h00 ||
                  w[23:16] == 8'h00 || w[31:24] == 8'h00) begin
                phase = PhToken;
              end
            end
          end
          PhHlen: begin
            if (!inb) begin
              st    = StHdrTrunc;
              phase = PhIdle;
            end else begin
              consumed++;
              held_length = w;
              phase       = PhHoff;
            end
          end
          PhHoff: begin
            if (!inb) begin
              st    = StHdrTrunc;
              phase = PhIdle;
            end else begin
              consumed++;
              held_offset = w;
              // padded length in words, computed wide so it cannot wrap
              vw   = ({32'd0, held_length} + 64'd3) >> 2;
              room = 32'(word_count - consumed);
              if (w >= strings_bytes) begin
                st    = StNameOffOut;
                phase = PhIdle;
              end else if (vw > room) begin
                st    = StValueTrunc;
                phase = PhIdle;
              end else begin
                value_left = 32'(vw);
                phase      = (vw != 0) ? PhValue : PhToken;
              end
            end
          end
          PhValue: begin
            if (!inb) begin
              st    = StValueTrunc;
              phase = PhIdle;
            end else begin
              consumed++;
              if (value_left > 0) value_left--;
              if (value_left == 0) phase = PhToken;
            end
          end
          default: begin
            st    = StIgnored;
            phase = PhIdle;
          end
        endcase
      end

      // Tally walk outcomes for the summary
      status_seen[st] = 1'b1;
      if (st == StComplete) begin
        walks_completed++;
      end else if (st != StOk && st != StIgnored) begin
        walks_failed++;
      end

      exp.status        = st;
      exp.token_kind    = kd;
      exp.nest_depth    = 7'(depth);
      exp.value_length  = held_length;
      exp.name_offset   = held_offset;
      expected_q.push_back(exp);
    endfunction

    // Match one result beat against the oldest expectation
    function void check_result(logic [StatusW-1:0] st, logic [KindW-1:0] kd,
                               logic [DepthW-1:0] dp, logic [WordW-1:0] len,
                               logic [WordW-1:0] off);
      result_t exp;
      bit      bad;
      results_checked++;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("result beat %0d with no word pending: status %0d kind %0d",
                   results_checked, st, kd);
        end
        return;
      end
      exp = expected_q.pop_front();
      bad = (st !== exp.status) || (kd !== exp.token_kind) ||
            (dp !== exp.nest_depth) || (len !== exp.value_length) ||
            (off !== exp.name_offset);
      if (bad) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch at result %0d (expected/actual):", results_checked);
          $display("  status %0d/%0d kind %0d/%0d depth %0d/%0d",
                   exp.status, st, exp.token_kind, kd, exp.nest_depth, dp);
          $display("  length %h/%h offset %h/%h",
                   exp.value_length, len, exp.name_offset, off);
        end
      end
    endfunction
  endclass

endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FDT structure block checker testbench
// Drives directed and random structure blocks (well-formed, truncated and
// corrupted) under several block and strings bounds, with random stalls on
// both channels, and checks every result beat against a predicted walk.
// ----------------------------------------------------------------------------
module testbench;
  import fdtsbc_pkg::*;
  import fdtsbc_tb_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic        FuncWord   = ~FuncStart;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  fdtsbc_in_if  word_if ();
  fdtsbc_out_if res_if ();
  fdtsbc_cfg_if reg_if ();

  fdt_struct_block_checker u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (word_if),
    .out_o  (res_if),
    .cfg_i  (reg_if)
  );

  fdt_walk_scoreboard walk_sb = new();

  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned words_sent;
  int unsigned blocks_sent;
  int unsigned cur_strings;
  int unsigned cycles;

  always #4 clk = ~clk;

  // End the run if it hangs
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d beats outstanding",
                 cycles, walk_sb.pending());
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Hold off result beats in random bursts
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 18);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Check each accepted result beat
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      walk_sb.check_result(res_if.status, res_if.token_kind, res_if.nest_depth,
                           res_if.value_length, res_if.name_offset);
    end
  end

  function automatic logic [31:0] nonzero_word();
    return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
  endfunction

  // Send one beat, with an occasional idle burst ahead of it
  task automatic send_word(logic func, logic [31:0] w);
    if (gaps_on && $urandom_range(0, 11) == 0) begin
      word_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    word_if.valid <= 1'b1;
    word_if.func  <= func;
    word_if.word  <= w;
    @(posedge clk);
    while (!word_if.ready) @(posedge clk);
    walk_sb.note_word(func, w);
    words_sent++;
  endtask

  // Stop sending and let every pending result drain
  task automatic wait_drained();
    word_if.valid <= 1'b0;
    while (walk_sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both bound registers back to back
  task automatic write_config(logic [CfgDataW-1:0] wc, logic [CfgDataW-1:0] ss);
    reg_if.valid <= 1'b1;
    reg_if.index <= RegStructWordCount;
    reg_if.data  <= wc;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
    walk_sb.write_reg(RegStructWordCount, wc);
    reg_if.index <= RegStringsSize;
    reg_if.data  <= ss;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
    walk_sb.write_reg(RegStringsSize, ss);
    reg_if.valid <= 1'b0;
    cur_strings = ss;
  endtask

  // Build one structure block with random content, optionally damage it, send it
  task automatic send_block(int unsigned max_nest, int unsigned n_tok, bit deep, bit noisy);
    logic [31:0] blk[$];
    int unsigned nest;
    bit          after_sub;
    int unsigned pick;
    int unsigned sel;
    int unsigned k;
    logic [31:0] len;
    logic [31:0] off;
    logic [31:0] w;
    nest      = 0;
    after_sub = 1'b0;
    blk.push_back(TokBeginNode);
    blk.push_back(RootName);
    if (deep) begin
      // Nest to just under or right up to the depth limit, sometimes one or two past it
      k = $urandom_range(MaxDepth - 1, MaxDepth + 2);
      repeat (k) begin
        blk.push_back(TokBeginNode);
        w   = nonzero_word();
        sel = $urandom_range(0, 3);
        w[8*sel +: 8] = 8'h00;
        blk.push_back(w);
      end
      repeat (k + 1) blk.push_back(TokEndNode);
    end else begin
      repeat (n_tok) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          blk.push_back(TokNop);
        end else if (pick <= 3 && !after_sub) begin
          // Property: header, then the value padded to whole words (two words if over 96 bytes)
          len = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 24);
          if (cur_strings == 0 || $urandom_range(0, 9) == 0) begin
            off = $urandom_range(0, 1) ? cur_strings + $urandom_range(0, 2) : $urandom;
          end else begin
            off = $urandom_range(0, cur_strings - 1);
          end
          blk.push_back(TokProp);
          blk.push_back(len);
          blk.push_back(off);
          k = (len <= 96) ? (len + 3) / 4 : 2;
          repeat (k) blk.push_back($urandom);
        end else if (pick <= 6 && nest < max_nest) begin
          // Begin node: name words, the last one holding a zero byte
          blk.push_back(TokBeginNode);
          repeat ($urandom_range(0, 2)) blk.push_back(nonzero_word());
          w   = ($urandom_range(0, 5) == 0) ? 32'h0 : nonzero_word();
          sel = $urandom_range(0, 3);
          w[8*sel +: 8] = 8'h00;
          blk.push_back(w);
          nest++;
          after_sub = 1'b0;
        end else if (nest > 0) begin
          blk.push_back(TokEndNode);
          nest--;
          after_sub = 1'b1;
        end else begin
          blk.push_back(TokNop);
        end
      end
      repeat (nest + 1) blk.push_back(TokEndNode);
    end

    // Damage some blocks: a bad word, a cut tail, or stray beats up front
    if (noisy) begin
      case ($urandom_range(0, 7))
        0: begin
          k      = $urandom_range(0, blk.size() - 1);
          blk[k] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 6);
        end
        1: begin
          k = $urandom_range(1, blk.size() - 1);
          while (blk.size() > k) void'(blk.pop_back());
        end
        2: begin
          repeat ($urandom_range(1, 3)) send_word($urandom_range(0, 1), $urandom);
        end
        default: ;
      endcase
    end

    send_word(FuncStart, $urandom);
    foreach (blk[i]) send_word(FuncWord, blk[i]);
    if (noisy && $urandom_range(0, 4) == 0) send_word(FuncWord, $urandom);
    blocks_sent++;
  endtask

  // Pick random idling for the next block
  task automatic shuffle_idling();
    gaps_on   = $urandom_range(0, 3) != 0;
    stalls_on = $urandom_range(0, 3) != 0;
  endtask

  initial begin
    int unsigned goal;
    word_if.valid <= 1'b0;
    word_if.func  <= FuncStart;
    word_if.word  <= '0;
    reg_if.valid  <= 1'b0;
    reg_if.index  <= RegStructWordCount;
    reg_if.data   <= '0;
    words_sent  = 0;
    blocks_sent = 0;
    cur_strings = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset bounds: a word before any start, then a root beyond a zero-length block
    send_word(FuncWord, 32'hFFFF_FFFF);
    send_word(FuncStart, 32'hFFFF_FFFF);
    send_word(FuncWord, TokBeginNode);

    wait_drained();
    write_config(24'hFF_FFFF, 24'h00_0100);
    // Nop, property, named subnode, then a property after a subnode
    send_word(FuncStart, 32'h0);
    send_word(FuncWord, TokBeginNode);
    send_word(FuncWord, RootName);
    send_word(FuncWord, TokNop);
    send_word(FuncWord, TokProp);
    send_word(FuncWord, 32'd5);
    send_word(FuncWord, 32'h0000_00FF);
    send_word(FuncWord, 32'hFFFF_FFFF);
    send_word(FuncWord, 32'h0);
    send_word(FuncWord, TokBeginNode);
    send_word(FuncWord, 32'h6162_6364);
    send_word(FuncWord, 32'h0065_6667);
    send_word(FuncWord, TokEndNode);
    send_word(FuncWord, TokProp);
    send_word(FuncWord, 32'h0);
    // Largest length: padded length must not wrap
    send_word(FuncStart, 32'h0);
    send_word(FuncWord, TokBeginNode);
    send_word(FuncWord, RootName);
    send_word(FuncWord, TokProp);
    send_word(FuncWord, 32'hFFFF_FFFF);
    send_word(FuncWord, 32'h0);
    // Unknown token, then restart in the middle of a walk and complete it
    send_word(FuncStart, 32'h0);
    send_word(FuncWord, TokBeginNode);
    send_word(FuncWord, RootName);
    send_word(FuncWord, 32'hFFFF_FFFF);
    send_word(FuncStart, 32'h0);
    send_word(FuncWord, TokBeginNode);
    send_word(FuncStart, 32'h0);
    send_word(FuncWord, TokBeginNode);
    send_word(FuncWord, RootName);
    send_word(FuncWord, TokEndNode);

    // Broad walks under the largest block bound; pause until drained first
    wait_drained();
    write_config(24'hFF_FFFF, 24'($urandom_range(1, 1024)));
    while (words_sent < 550) begin
      shuffle_idling();
      send_block($urandom_range(1, 4), $urandom_range(1, 12), 1'b0, 1'b1);
    end

    // Tight block bounds so that words run past the end in every phase
    repeat (3) begin
      wait_drained();
      write_config(24'($urandom_range(2, 40)), 24'($urandom_range(0, 64)));
      goal = words_sent + 150;
      while (words_sent < goal) begin
        shuffle_idling();
        send_block($urandom_range(1, 3), $urandom_range(1, 10), 1'b0, 1'b1);
      end
    end

    // Widest strings area, nesting at and past the depth limit
    wait_drained();
    write_config(24'hFF_FFFF, 24'hFF_FFFF);
    send_block(0, 0, 1'b1, 1'b0);
    send_block(0, 0, 1'b1, 1'b0);
    while (words_sent < 1300) begin
      shuffle_idling();
      send_block($urandom_range(1, 5), $urandom_range(1, 12), 1'b0, 1'b1);
    end

    // Both bounds zero
    wait_drained();
    write_config(24'h0, 24'h0);
    repeat (3) send_block(2, 4, 1'b0, 1'b0);

    // Last stretch without idling on either side
    wait_drained();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_config(24'hFF_FFFF, 24'h00_0040);
    while (words_sent < 1550) begin
      send_block($urandom_range(1, 4), $urandom_range(1, 12), 1'b0, 1'b1);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d words in %0d blocks; %0d walks completed, %0d ended on a check error",
             words_sent, blocks_sent, walk_sb.walks_completed, walk_sb.walks_failed);
    $display("%0d of 12 status codes seen, %0d result beats checked, %0d failures",
             $countones(walk_sb.status_seen), walk_sb.results_checked, walk_sb.failures);
    if (walk_sb.failures == 0 && walk_sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
